/* rtl/ffha_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int unsigned HEAP_BYTES_DEF = 65536;
  localparam int unsigned HDR_BYTES      = 24;
  localparam int unsigned MIN_SPLIT      = 32;
  localparam int unsigned SIZE_W         = 17;
  localparam int unsigned ADDR_W         = 64;

  localparam logic [ADDR_W-1:0] HEAP_BASE_RST = 64'hFFFF_9000_0000_0000;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_OOM    = 2'd1;
  localparam logic [1:0] ST_NONE   = 2'd2;
  localparam logic [1:0] ST_BADPTR = 2'd3;

endpackage : ffha_pkg
`default_nettype wire

/* rtl/ffha_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ffha interfaces
// Request, response and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffha_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [16:0] request_size;
  logic [63:0] free_address;
  modport source (output valid, cmd, request_size, free_address, input ready);
  modport sink   (input valid, cmd, request_size, free_address, output ready);
endinterface : ffha_req_if

interface ffha_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_address;
  logic [1:0]  status;
  modport source (output valid, block_address, status, input ready);
  modport sink   (input valid, block_address, status, output ready);
endinterface : ffha_rsp_if

interface ffha_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface : ffha_cfg_if
`default_nettype wire

/* rtl/ffha_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_mem
// Block header store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffha_mem #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned WIDTH = 18
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule : ffha_mem
`default_nettype wire

/* rtl/first_fit_heap_allocator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with block split on allocate and coalesce on free.
// ----------------------------------------------------------------------------
// Allocate walks the block list, reading each header, and writes a tail
// header first when the block is split. Free checks the pointer, marks its
// block free, then walks the heap merging free neighbours. One transaction
// at a time. Every header read uses the single header memory read port.
// After reset a clearing pass writes all HEAP_BYTES/8 header entries; no
// request is taken meanwhile. Config writes always taken.
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
  input wire logic clk,
  input wire logic rst,
  ffha_req_if.sink   req,
  ffha_rsp_if.source rsp,
  ffha_cfg_if.sink   cfg
);
  import ffha_pkg::*;

  localparam int unsigned GRAN = HEAP_BYTES / 8;
  localparam int unsigned IW   = $clog2(GRAN);
  localparam int unsigned SZW  = $clog2(HEAP_BYTES);
  localparam int unsigned OW   = SZW + 2;
  localparam int unsigned CW   = (OW > 19) ? OW : 19;
  localparam int unsigned EW   = SZW + 2;

  localparam logic [CW-1:0]  HEAP_C = CW'(HEAP_BYTES);
  localparam logic [CW-1:0]  HDR_C  = CW'(HDR_BYTES);
  localparam logic [CW-1:0]  SPL_C  = CW'(MIN_SPLIT);
  localparam logic [SZW-1:0] RST_SZ = SZW'(HEAP_BYTES - HDR_BYTES);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_A_RD   = 4'd2;
  localparam logic [3:0] S_A_EV   = 4'd3;
  localparam logic [3:0] S_A_SPL  = 4'd4;
  localparam logic [3:0] S_A_MRK  = 4'd5;
  localparam logic [3:0] S_F_SUB  = 4'd6;
  localparam logic [3:0] S_F_RNG  = 4'd7;
  localparam logic [3:0] S_F_EV   = 4'd8;
  localparam logic [3:0] S_M_RD   = 4'd9;
  localparam logic [3:0] S_M_LD   = 4'd10;
  localparam logic [3:0] S_M_NXT  = 4'd11;
  localparam logic [3:0] S_M_NX   = 4'd12;
  localparam logic [3:0] S_M_WCUR = 4'd13;
  localparam logic [3:0] S_M_INV  = 4'd14;
  localparam logic [3:0] S_FIN    = 4'd15;

  logic [3:0]     state;
  logic [IW-1:0]  clr_idx;
  logic [63:0]    heap_base;
  logic           cmd;
  logic [16:0]    req_size;
  logic [63:0]    free_addr;
  logic [63:0]    foff;
  logic [OW-1:0]  off;
  logic [OW-1:0]  nxt;
  logic [OW-1:0]  tail;
  logic [SZW-1:0] tail_sz;
  logic [SZW-1:0] mark_sz;
  logic           cur_v, cur_f;
  logic [SZW-1:0] cur_sz;
  logic [1:0]     fin_st;
  logic           rsp_valid;
  logic [63:0]    rsp_addr;
  logic [1:0]     rsp_st;

  logic           we;
  logic [IW-1:0]  waddr, raddr;
  logic [EW-1:0]  wdata, rdata;
  logic           rd_v, rd_f;
  logic [SZW-1:0] rd_sz;
  logic [CW-1:0]  need, have, sum;

  assign rd_v  = rdata[EW-1];
  assign rd_f  = rdata[EW-2];
  assign rd_sz = rdata[SZW-1:0];
  assign need  = (CW'(req_size) + CW'(7)) & ~CW'(7);
  assign have  = CW'(rd_sz);

  ffha_mem #(.DEPTH(GRAN), .WIDTH(EW)) u_mem (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  always_comb begin
    we    = 1'b0;
    waddr = off[IW+2:3];
    wdata = '0;
    raddr = off[IW+2:3];
    sum   = CW'(off) + HDR_C + CW'(cur_sz);
    unique case (state)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_idx;
        wdata = (clr_idx == '0) ? {1'b1, 1'b1, RST_SZ} : '0;
      end
      S_A_EV:   sum = CW'(off) + HDR_C + ((rd_f && have >= need) ? need : have);
      S_A_SPL: begin
        we = 1'b1; waddr = tail[IW+2:3]; wdata = {1'b1, 1'b1, tail_sz};
      end
      S_A_MRK: begin
        we = 1'b1; wdata = {1'b1, 1'b0, mark_sz};
      end
      S_F_RNG:  raddr = foff[IW+2:3];
      S_F_EV: begin
        we = rd_v && !rd_f; wdata = {1'b1, 1'b1, rd_sz};
      end
      S_M_NXT:  raddr = sum[IW+2:3];
      S_M_NX:   sum = CW'(cur_sz) + HDR_C + CW'(rd_sz);
      S_M_WCUR: begin
        we = 1'b1; wdata = {cur_v, cur_f, cur_sz};
      end
      S_M_INV: begin
        we = 1'b1; waddr = nxt[IW+2:3]; wdata = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_idx   <= '0;
      heap_base <= HEAP_BASE_RST;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        heap_base <= cfg.data;
      end
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == IW'(GRAN - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid && !rsp_valid) begin
            cmd       <= req.cmd;
            req_size  <= req.request_size;
            free_addr <= req.free_address;
            off       <= '0;
            if (req.cmd == CMD_ALLOC) begin
              if (req.request_size == '0) begin
                fin_st <= ST_NONE; state <= S_FIN;
              end else begin
                state <= S_A_RD;
              end
            end else if (req.free_address == '0) begin
              fin_st <= ST_NONE; state <= S_FIN;
            end else begin
              state <= S_F_SUB;
            end
          end
        end
        S_A_RD: state <= S_A_EV;
        S_A_EV: begin
          if (!rd_v) begin
            fin_st <= ST_OOM; state <= S_FIN;
          end else if (rd_f && have >= need) begin
            fin_st  <= ST_DONE;
            tail    <= sum[OW-1:0];
            tail_sz <= SZW'(have - need - HDR_C);
            if (have > need + SPL_C && sum < HEAP_C) begin
              mark_sz <= SZW'(need);
              state   <= S_A_SPL;
            end else begin
              mark_sz <= rd_sz;
              state   <= S_A_MRK;
            end
          end else if (sum >= HEAP_C) begin
            fin_st <= ST_OOM; state <= S_FIN;
          end else begin
            off   <= sum[OW-1:0];
            state <= S_A_RD;
          end
        end
        S_A_SPL: state <= S_A_MRK;
        S_A_MRK: state <= S_FIN;
        S_F_SUB: begin
          foff  <= free_addr - heap_base - 64'(HDR_BYTES);
          state <= S_F_RNG;
        end
        S_F_RNG: begin
          if (foff >= 64'(HEAP_BYTES) || foff[2:0] != 3'd0) begin
            fin_st <= ST_BADPTR; state <= S_FIN;
          end else begin
            off   <= foff[OW-1:0];
            state <= S_F_EV;
          end
        end
        S_F_EV: begin
          if (!rd_v || rd_f) begin
            fin_st <= ST_BADPTR; state <= S_FIN;
          end else begin
            fin_st <= ST_DONE;
            off    <= '0;
            state  <= S_M_RD;
          end
        end
        S_M_RD: state <= S_M_LD;
        S_M_LD: begin
          cur_v <= rd_v; cur_f <= rd_f; cur_sz <= rd_sz;
          state <= S_M_NXT;
        end
        S_M_NXT: begin
          nxt <= sum[OW-1:0];
          if (!cur_v || sum >= HEAP_C) begin
            state <= S_FIN;
          end else begin
            state <= S_M_NX;
          end
        end
        S_M_NX: begin
          if (!rd_v) begin
            state <= S_FIN;
          end else if (cur_f && rd_f) begin
            cur_sz <= sum[SZW-1:0];
            state  <= S_M_WCUR;
          end else begin
            off <= nxt;
            cur_v <= rd_v; cur_f <= rd_f; cur_sz <= rd_sz;
            state <= S_M_NXT;
          end
        end
        S_M_WCUR: state <= S_M_INV;
        S_M_INV:  state <= S_M_NXT;
        S_FIN: begin
          rsp_valid <= 1'b1;
          rsp_st    <= fin_st;
          rsp_addr  <= (cmd == CMD_ALLOC && fin_st == ST_DONE) ?
                       heap_base + 64'(off) + 64'(HDR_BYTES) : '0;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready         = (state == S_IDLE) && !rsp_valid;
  assign rsp.valid         = rsp_valid;
  assign rsp.block_address = rsp_addr;
  assign rsp.status        = rsp_st;
  assign cfg.ready         = 1'b1;

`ifndef SYNTHESIS
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !we) else $error("header write while idle");
  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_st != ST_DONE |-> rsp_addr == '0)
    else $error("nonzero address on failed transaction");
  a_rsp_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_FIN)
    else $error("response raised outside finish");
`endif

endmodule : first_fit_heap_allocator
`default_nettype wire

/* tb/tb_first_fit_heap_allocator.sv */
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator
// Self-checking bench for the first-fit heap allocator. A behavioral copy
// of the header table predicts status and block address for every request.
// Directed corner requests come first. Random allocate/free traffic follows,
// under several heap base settings. Both channels idle at random, and one
// long response hold-off fills the block.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  localparam int unsigned HEAP  = HEAP_BYTES_DEF;
  localparam int unsigned GRANS = HEAP / 8;
  localparam int unsigned WDOG_LIMIT = 200000;

  typedef struct packed {
    logic [63:0] block_address;
    logic [1:0]  status;
  } rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ffha_req_if req();
  ffha_rsp_if rsp();
  ffha_cfg_if cfg();

  first_fit_heap_allocator #(.HEAP_BYTES(HEAP)) DUT (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted header table
  logic [63:0]  base_q;
  bit           hv [GRANS];
  bit           hf [GRANS];
  int unsigned  hs [GRANS];

  rsp_t         pending_rsp[$];
  int unsigned  live_off[$];
  int unsigned  last_freed;
  int           errors = 0;
  int           n_alloc = 0, n_free = 0, n_oom = 0, n_bad = 0;
  bit           quiet = 1'b0;
  bit           hold_req = 1'b0;
  int           hold_cnt = 0;
  int           stall_left = 0;
  int           idle_cycles = 0;

  task automatic heap_reset();
    for (int i = 0; i < GRANS; i++) begin
      hv[i] = 0; hf[i] = 0; hs[i] = 0;
    end
    hv[0] = 1; hf[0] = 1; hs[0] = HEAP - HDR_BYTES;
    base_q = HEAP_BASE_RST;
  endtask

  function automatic logic [63:0] next_blk(logic [63:0] off);
    return off + HDR_BYTES + hs[off >> 3];
  endfunction

  task automatic coalesce();
    logic [63:0] off, nxt;
    off = 0;
    while (off < HEAP && hv[off >> 3]) begin
      nxt = next_blk(off);
      if (nxt >= HEAP || !hv[nxt >> 3]) break;
      if (hf[off >> 3] && hf[nxt >> 3]) begin
        hs[off >> 3] = hs[off >> 3] + HDR_BYTES + hs[nxt >> 3];
        hv[nxt >> 3] = 0; hf[nxt >> 3] = 0; hs[nxt >> 3] = 0;
      end else begin
        off = nxt;
      end
    end
  endtask

  task automatic predict_alloc(input logic [16:0] sz, output rsp_t r);
    logic [63:0] need, off, have, tail;
    r = '{block_address: 64'd0, status: ST_OOM};
    if (sz == 0) begin
      r.status = ST_NONE;
      return;
    end
    need = (64'(sz) + 7) & ~64'd7;
    off = 0;
    while (off < HEAP && hv[off >> 3]) begin
      have = hs[off >> 3];
      if (hf[off >> 3] && have >= need) begin
        if (have > need + HDR_BYTES + 8) begin
          tail = off + HDR_BYTES + need;
          if (tail < HEAP) begin
            hv[tail >> 3] = 1; hf[tail >> 3] = 1;
            hs[tail >> 3] = 32'(have - need - HDR_BYTES);
            hs[off >> 3] = 32'(need);
          end
        end
        hf[off >> 3] = 0;
        r.block_address = base_q + off + HDR_BYTES;
        r.status = ST_DONE;
        live_off.push_back(32'(off));
        return;
      end
      off = next_blk(off);
    end
  endtask

  task automatic predict_free(input logic [63:0] a, output rsp_t r);
    logic [63:0] off;
    r = '{block_address: 64'd0, status: ST_BADPTR};
    if (a == 0) begin
      r.status = ST_NONE;
      return;
    end
    off = a - base_q - HDR_BYTES;
    if (off >= HEAP || off[2:0] != 0) return;
    if (!hv[off >> 3] || hf[off >> 3]) return;
    hf[off >> 3] = 1;
    coalesce();
    r.status = ST_DONE;
    foreach (live_off[i]) if (live_off[i] == off) begin
      live_off.delete(i);
      break;
    end
    last_freed = 32'(off);
  endtask

  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(input logic c, input logic [16:0] sz, input logic [63:0] a);
    rsp_t r;
    int g;
    req.valid        <= 1'b1;
    req.cmd          <= c;
    req.request_size <= sz;
    req.free_address <= a;
    do @(posedge clk); while (!req.ready);
    if (c == CMD_ALLOC) predict_alloc(sz, r);
    else predict_free(a, r);
    pending_rsp.push_back(r);
    if (c == CMD_ALLOC) n_alloc++; else n_free++;
    if (r.status == ST_OOM) n_oom++;
    if (r.status == ST_BADPTR) n_bad++;
    g = gap_len();
    if (g > 0) begin
      req.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_base(input logic [63:0] v);
    drain();
    cfg.valid <= 1'b1;
    cfg.data  <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    base_q = v;
    @(posedge clk);
  endtask

  function automatic logic [16:0] rand_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2)  return 17'd0;
    if (r < 70) return 17'($urandom_range(1, 256));
    if (r < 95) return 17'($urandom_range(257, 4096));
    return 17'($urandom_range(4097, 65536));
  endfunction

  function automatic logic [63:0] free_addr_of(int unsigned off);
    return base_q + off + HDR_BYTES;
  endfunction

  task automatic send_random();
    int r;
    int unsigned off;
    r = $urandom_range(0, 99);
    if (r < 55 || (r < 92 && live_off.size() == 0)) begin
      send(CMD_ALLOC, rand_size(), {$urandom, $urandom});
    end else if (r < 92) begin
      off = live_off[$urandom_range(0, live_off.size() - 1)];
      send(CMD_FREE, 17'($urandom), free_addr_of(off));
    end else begin
      case ($urandom_range(0, 4))
        0: send(CMD_FREE, 17'($urandom), 64'd0);
        1: send(CMD_FREE, 17'($urandom), {$urandom, $urandom});
        2: send(CMD_FREE, 17'($urandom), free_addr_of(last_freed));
        3: send(CMD_FREE, 17'($urandom), free_addr_of($urandom_range(0, HEAP - 1)));
        default: send(CMD_FREE, 17'($urandom), base_q + HEAP + HDR_BYTES);
      endcase
    end
  endtask

  task automatic test_directed();
    logic [63:0] a0, a1, a2;
    send(CMD_ALLOC, 17'd0, 64'd0);
    send(CMD_ALLOC, 17'd65536, 64'd0);
    send(CMD_FREE, 17'd0, 64'd0);
    send(CMD_FREE, 17'd0, free_addr_of(0));
    send(CMD_ALLOC, 17'd65480, 64'd0);
    a0 = free_addr_of(0);
    send(CMD_ALLOC, 17'd1, 64'd0);
    send(CMD_FREE, 17'd0, a0);
    send(CMD_ALLOC, 17'd65472, 64'd0);
    send(CMD_ALLOC, 17'd8, 64'd0);
    send(CMD_FREE, 17'd0, a0);
    send(CMD_ALLOC, 17'd65512, 64'd0);
    send(CMD_FREE, 17'd0, a0);
    send(CMD_ALLOC, 17'd1, 64'd0);
    send(CMD_ALLOC, 17'd9, 64'd0);
    send(CMD_ALLOC, 17'd100, 64'd0);
    a1 = free_addr_of(32);
    a2 = free_addr_of(72);
    send(CMD_FREE, 17'd0, a1 + 4);
    send(CMD_FREE, 17'd0, a1 + 8);
    send(CMD_FREE, 17'd0, a1);
    send(CMD_FREE, 17'd0, a1);
    send(CMD_FREE, 17'd0, a0);
    send(CMD_FREE, 17'd0, a2);
    send(CMD_FREE, 17'd0, base_q + HEAP + HDR_BYTES);
    send(CMD_FREE, 17'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send(CMD_ALLOC, 17'd65536, 64'd0);
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_random();
    end
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    quiet = 1'b1;
    for (int i = 0; i < 30; i++) send_random();
    quiet = 1'b0;
  endtask

  task automatic test_base_phases();
    write_base(64'd0);
    test_random(150);
    write_base(64'hFFFF_FFFF_FFFF_FFFF);
    test_random(120);
    write_base({$urandom, $urandom});
    test_random(130);
    write_base(HEAP_BASE_RST);
    test_random(60);
  endtask

  // response ready with random stalls and one long hold-off
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      rsp.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_cnt <= 400;
      rsp.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < 25) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                 : $urandom_range(0, 2);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t unexpected transaction: addr %h status %0d", $realtime,
                 rsp.block_address, rsp.status);
      end else begin
        e = pending_rsp.pop_front();
        if (e.block_address !== rsp.block_address) begin
          errors++;
          $display("%0t block_address expected %h actual %h", $realtime,
                   e.block_address, rsp.block_address);
        end
        if (e.status !== rsp.status) begin
          errors++;
          $display("%0t status expected %0d actual %0d", $realtime, e.status, rsp.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("watchdog expired at %0t", $realtime);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    req.valid = 1'b0;
    req.cmd = CMD_ALLOC;
    req.request_size = '0;
    req.free_address = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    rsp.ready = 1'b0;
    heap_reset();
    last_freed = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(160);
    test_backpressure();
    test_base_phases();
    drain();
    $display("covered %0d allocates, %0d frees (%0d out of memory, %0d bad pointer)",
             n_alloc, n_free, n_oom, n_bad);
    $display("heap base settings: reset value, zero, all ones, random");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/ffha_pkg.sv
rtl/ffha_if.sv
rtl/ffha_mem.sv
rtl/first_fit_heap_allocator.sv
tb/tb_first_fit_heap_allocator.sv
